### hw/rtl/cpwf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpwf_pkg
// Shared types and fixed widths of the cheapest price window finder.
// ----------------------------------------------------------------------------
package cpwf_pkg;

	// width of the price ports and of the hour index ports
	localparam int unsigned OUT_PRICE_BITS = 32;
	localparam int unsigned IDX_BITS       = 5;
	// price field is widened to this before the low bits are taken
	localparam int unsigned RAW_BITS       = 64;

	// what the front decided about one beat
	typedef struct packed {
		logic track;
		logic last;
	} cls_t;

endpackage
`default_nettype wire

### hw/rtl/cpwf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpwf_front
// Accepts input beats, keeps the hour count and the stop flag of the run and
// tags every beat with its hour and whether it is tracked.
// ----------------------------------------------------------------------------
module cpwf_front #(
	parameter int unsigned HORIZON    = 24,
	parameter int unsigned PRICE_BITS = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0] price,
	input  wire logic                                    present,
	input  wire logic                                    last_hour,
	output logic                                         push_valid,
	input  wire logic                                    push_ready,
	output logic [PRICE_BITS+$clog2(HORIZON)+$bits(cpwf_pkg::cls_t)-1:0] push_data
);

	localparam int unsigned HOUR_BITS = $clog2(HORIZON);
	localparam int unsigned CNT_BITS  = $clog2(HORIZON + 1);

	logic [CNT_BITS-1:0]             cnt_q;
	logic                            stopped_q;
	logic                            in_horizon;
	logic                            accept;
	logic [cpwf_pkg::RAW_BITS-1:0]   raw;
	logic [PRICE_BITS-1:0]           p;
	logic [HOUR_BITS-1:0]            hour;
	cpwf_pkg::cls_t                  cls;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	assign in_horizon = (cnt_q < CNT_BITS'(HORIZON));
	assign raw    = {{(cpwf_pkg::RAW_BITS - cpwf_pkg::OUT_PRICE_BITS){1'b0}}, price};
	assign p      = raw[PRICE_BITS-1:0];
	assign hour   = cnt_q[HOUR_BITS-1:0];

	always_comb begin
		cls.track = in_horizon && !stopped_q && present;
		cls.last  = last_hour;
	end

	assign push_data = {p, hour, cls};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (last_hour) begin
				cnt_q     <= '0;
				stopped_q <= 1'b0;
			end else if (in_horizon) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				// first missing price ends tracking for the run
				if (!present)
					stopped_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/cpwf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpwf_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module cpwf_fifo #(
	parameter int unsigned WIDTH = 39
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/cpwf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpwf_back
// Keeps the last five tracked prices, sums the 3 and 6 hour windows, then
// updates the running minima and maxima and emits the result on the last beat.
// ----------------------------------------------------------------------------
module cpwf_back #(
	parameter int unsigned HORIZON    = 24,
	parameter int unsigned PRICE_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   pop_valid,
	output logic                                        pop_ready,
	input  wire logic [PRICE_BITS+$clog2(HORIZON)+$bits(cpwf_pkg::cls_t)-1:0] pop_data,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0]  lowest_price,
	output logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0]  highest_price,
	output logic                                        any_price,
	output logic [cpwf_pkg::IDX_BITS-1:0]               cheapest_hour,
	output logic                                        have_three,
	output logic [cpwf_pkg::IDX_BITS-1:0]               cheapest_three_start,
	output logic                                        have_six,
	output logic [cpwf_pkg::IDX_BITS-1:0]               cheapest_six_start
);

	localparam int unsigned HOUR_BITS = $clog2(HORIZON);
	localparam int unsigned SUM_BITS  = PRICE_BITS + 3;
	localparam int unsigned PAD_BITS  = cpwf_pkg::RAW_BITS - PRICE_BITS;

	// popped entry
	logic signed [PRICE_BITS-1:0] p;
	logic [HOUR_BITS-1:0]         hour;
	cpwf_pkg::cls_t               cls;
	logic                         pop;

	// price history, newest first
	logic signed [PRICE_BITS-1:0] hist_q [5];
	logic signed [SUM_BITS-1:0]   ext_p;
	logic signed [SUM_BITS-1:0]   ext_h [5];
	logic signed [SUM_BITS-1:0]   s3;
	logic signed [SUM_BITS-1:0]   s6;

	// stage 1
	logic                         valid_s1;
	logic signed [PRICE_BITS-1:0] price_s1;
	logic [HOUR_BITS-1:0]         hour_s1;
	logic                         track_s1;
	logic                         last_s1;
	logic signed [SUM_BITS-1:0]   s3_s1;
	logic signed [SUM_BITS-1:0]   s6_s1;
	logic                         stall;
	logic                         fire;

	// running results
	logic                         seen_q;
	logic signed [PRICE_BITS-1:0] low_q;
	logic signed [PRICE_BITS-1:0] high_q;
	logic [HOUR_BITS-1:0]         best_hour_q;
	logic                         three_valid_q;
	logic signed [SUM_BITS-1:0]   best_three_q;
	logic [HOUR_BITS-1:0]         three_idx_q;
	logic                         six_valid_q;
	logic signed [SUM_BITS-1:0]   best_six_q;
	logic [HOUR_BITS-1:0]         six_idx_q;

	logic                         seen_n;
	logic signed [PRICE_BITS-1:0] low_n;
	logic signed [PRICE_BITS-1:0] high_n;
	logic [HOUR_BITS-1:0]         best_hour_n;
	logic                         three_valid_n;
	logic signed [SUM_BITS-1:0]   best_three_n;
	logic [HOUR_BITS-1:0]         three_idx_n;
	logic                         six_valid_n;
	logic signed [SUM_BITS-1:0]   best_six_n;
	logic [HOUR_BITS-1:0]         six_idx_n;

	logic signed [cpwf_pkg::RAW_BITS-1:0] low_w;
	logic signed [cpwf_pkg::RAW_BITS-1:0] high_w;

	// output register
	logic                                       out_valid_q;
	logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0] low_out_q;
	logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0] high_out_q;
	logic                                       any_out_q;
	logic [cpwf_pkg::IDX_BITS-1:0]              hour_out_q;
	logic                                       three_out_q;
	logic [cpwf_pkg::IDX_BITS-1:0]              three_idx_out_q;
	logic                                       six_out_q;
	logic [cpwf_pkg::IDX_BITS-1:0]              six_idx_out_q;

	assign {p, hour, cls} = pop_data;

	// only a last beat needs the output register
	assign stall     = valid_s1 && last_s1 && out_valid_q && !out_ready;
	assign pop_ready = !stall;
	assign pop       = pop_valid && pop_ready;
	assign fire      = valid_s1 && !stall;

	assign ext_p = {{3{p[PRICE_BITS-1]}}, p};
	always_comb begin
		for (int k = 0; k < 5; k++)
			ext_h[k] = {{3{hist_q[k][PRICE_BITS-1]}}, hist_q[k]};
	end
	assign s3 = ext_p + ext_h[0] + ext_h[1];
	assign s6 = (ext_p + ext_h[0]) + (ext_h[1] + ext_h[2]) + (ext_h[3] + ext_h[4]);

	always_ff @(posedge clk) begin
		if (pop) begin
			price_s1 <= p;
			hour_s1  <= hour;
			track_s1 <= cls.track;
			last_s1  <= cls.last;
			s3_s1    <= s3;
			s6_s1    <= s6;
			if (cls.track) begin
				for (int k = 4; k > 0; k--)
					hist_q[k] <= hist_q[k-1];
				hist_q[0] <= p;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!stall)
			valid_s1 <= pop;
	end

	always_comb begin
		seen_n        = seen_q;
		low_n         = low_q;
		high_n        = high_q;
		best_hour_n   = best_hour_q;
		three_valid_n = three_valid_q;
		best_three_n  = best_three_q;
		three_idx_n   = three_idx_q;
		six_valid_n   = six_valid_q;
		best_six_n    = best_six_q;
		six_idx_n     = six_idx_q;
		if (valid_s1 && track_s1) begin
			seen_n = 1'b1;
			if (!seen_q || price_s1 < low_q) begin
				low_n       = price_s1;
				best_hour_n = hour_s1;
			end
			if (!seen_q || price_s1 > high_q)
				high_n = price_s1;
			// ties keep the earlier window
			if (hour_s1 >= HOUR_BITS'(2) && (!three_valid_q || s3_s1 < best_three_q)) begin
				three_valid_n = 1'b1;
				best_three_n  = s3_s1;
				three_idx_n   = hour_s1 - HOUR_BITS'(2);
			end
			if (hour_s1 >= HOUR_BITS'(5) && (!six_valid_q || s6_s1 < best_six_q)) begin
				six_valid_n = 1'b1;
				best_six_n  = s6_s1;
				six_idx_n   = hour_s1 - HOUR_BITS'(5);
			end
		end
	end

	assign low_w  = {{PAD_BITS{low_n[PRICE_BITS-1]}}, low_n};
	assign high_w = {{PAD_BITS{high_n[PRICE_BITS-1]}}, high_n};

	always_ff @(posedge clk) begin
		if (fire) begin
			low_q        <= low_n;
			high_q       <= high_n;
			best_hour_q  <= best_hour_n;
			best_three_q <= best_three_n;
			three_idx_q  <= three_idx_n;
			best_six_q   <= best_six_n;
			six_idx_q    <= six_idx_n;
		end
		if (fire && last_s1) begin
			low_out_q       <= seen_n ? low_w[cpwf_pkg::OUT_PRICE_BITS-1:0] : '0;
			high_out_q      <= seen_n ? high_w[cpwf_pkg::OUT_PRICE_BITS-1:0] : '0;
			any_out_q       <= seen_n;
			hour_out_q      <= seen_n ? cpwf_pkg::IDX_BITS'(best_hour_n) : '0;
			three_out_q     <= three_valid_n;
			three_idx_out_q <= three_valid_n ? cpwf_pkg::IDX_BITS'(three_idx_n) : '0;
			six_out_q       <= six_valid_n;
			six_idx_out_q   <= six_valid_n ? cpwf_pkg::IDX_BITS'(six_idx_n) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			three_valid_q <= 1'b0;
			six_valid_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire) begin
				if (last_s1) begin
					seen_q        <= 1'b0;
					three_valid_q <= 1'b0;
					six_valid_q   <= 1'b0;
				end else begin
					seen_q        <= seen_n;
					three_valid_q <= three_valid_n;
					six_valid_q   <= six_valid_n;
				end
			end
			if (fire && last_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign lowest_price         = low_out_q;
	assign highest_price        = high_out_q;
	assign any_price            = any_out_q;
	assign cheapest_hour        = hour_out_q;
	assign have_three           = three_out_q;
	assign cheapest_three_start = three_idx_out_q;
	assign have_six             = six_out_q;
	assign cheapest_six_start   = six_idx_out_q;

endmodule
`default_nettype wire

### hw/rtl/cheapest_price_window_finder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cheapest_price_window_finder_top
// Finds the price range, the cheapest hour and the cheapest 3 and 6 hour
// windows over the first HORIZON hours of each run of hourly prices.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   price, present, last_hour
//   out      out_valid / out_ready lowest_price ... cheapest_six_start
//
// One beat per cycle is taken while the queue has room; after its last beat is
// accepted, a result passes the queue write, the window sums into stage 1 and
// the compare into the output register.
// Reset clears the hour count, the stop flag, the queue and all valid flags.
// A full output register stalls the back only while a last beat is in stage 1;
// beats behind it wait; the queue absorbs short stalls before in_ready drops.
// ----------------------------------------------------------------------------
module cheapest_price_window_finder_top #(
	parameter int unsigned HORIZON    = 24,
	parameter int unsigned PRICE_BITS = 32
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       in_valid,
	output logic                                            in_ready,
	input  wire logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0] price,
	input  wire logic                                       present,
	input  wire logic                                       last_hour,
	output logic                                            out_valid,
	input  wire logic                                       out_ready,
	output logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0]      lowest_price,
	output logic signed [cpwf_pkg::OUT_PRICE_BITS-1:0]      highest_price,
	output logic                                            any_price,
	output logic [cpwf_pkg::IDX_BITS-1:0]                   cheapest_hour,
	output logic                                            have_three,
	output logic [cpwf_pkg::IDX_BITS-1:0]                   cheapest_three_start,
	output logic                                            have_six,
	output logic [cpwf_pkg::IDX_BITS-1:0]                   cheapest_six_start
);

	localparam int unsigned ENTRY_BITS =
		PRICE_BITS + $clog2(HORIZON) + $bits(cpwf_pkg::cls_t);

	logic                  push_valid;
	logic                  push_ready;
	logic [ENTRY_BITS-1:0] push_data;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [ENTRY_BITS-1:0] pop_data;

	cpwf_front #(
		.HORIZON    (HORIZON),
		.PRICE_BITS (PRICE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.price      (price),
		.present    (present),
		.last_hour  (last_hour),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cpwf_fifo #(
		.WIDTH (ENTRY_BITS)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cpwf_back #(
		.HORIZON    (HORIZON),
		.PRICE_BITS (PRICE_BITS)
	) u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.pop_valid            (pop_valid),
		.pop_ready            (pop_ready),
		.pop_data             (pop_data),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.lowest_price         (lowest_price),
		.highest_price        (highest_price),
		.any_price            (any_price),
		.cheapest_hour        (cheapest_hour),
		.have_three           (have_three),
		.cheapest_three_start (cheapest_three_start),
		.have_six             (have_six),
		.cheapest_six_start   (cheapest_six_start)
	);

endmodule
`default_nettype wire
